// ===== hdl/nvs_pkg.sv =====
package nvs_pkg;

	// Table size and coordinate width
	localparam int MAX_SITES  = 64;
	localparam int COORD_BITS = 10;

	// Fixed field widths of the item formats
	localparam int KIND_W   = 1;
	localparam int SIDX_W   = 6;
	localparam int PT_W     = 10;
	localparam int COLOR_W  = 32;
	localparam int DIST_W   = 11;
	localparam int SCOUNT_W = 7;
	localparam int METRIC_W = 2;
	localparam int CFGIDX_W = 1;

	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 56;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Derived widths
	localparam int IDX_W   = $clog2(MAX_SITES);
	localparam int CNT_W   = $clog2(MAX_SITES + 1);
	localparam int SQ2_W   = 2 * COORD_BITS;
	localparam int SQ_W    = 2 * COORD_BITS + 1;
	localparam int ROOT_W  = COORD_BITS + 1;
	localparam int VPAD_W  = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int ENTRY_W = 2 * COORD_BITS + COLOR_W;
	localparam int CMP_W   = (ROOT_W > DIST_W) ? ROOT_W : DIST_W;

	// Codes
	localparam logic [KIND_W-1:0] KIND_LOAD  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

	localparam logic [METRIC_W-1:0] MET_EUCLID    = 2'd0;
	localparam logic [METRIC_W-1:0] MET_MANHATTAN = 2'd1;
	localparam logic [METRIC_W-1:0] MET_CHEBYSHEV = 2'd2;

	localparam logic [CFGIDX_W-1:0] CFG_SITE_COUNT = 1'b0;
	localparam logic [CFGIDX_W-1:0] CFG_METRIC     = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FETCH,
		ST_EMIT
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic             load;
		logic             start;
		logic             issue;
		logic             issue_last;
		logic [IDX_W-1:0] scan_idx;
		logic             fetch;
		logic             emit;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic done;
	} sts_t;

	// Sites scanned per query: zero counts as one, saturate at table size
	function automatic logic [CNT_W-1:0] eff_count(input logic [SCOUNT_W-1:0] c);
		int unsigned ci;
		ci = c;
		if (ci == 0)
			ci = 1;
		if (ci > MAX_SITES)
			ci = MAX_SITES;
		return CNT_W'(ci);
	endfunction

	function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] d);
		logic [CMP_W-1:0] w;
		w = CMP_W'(d);
		if (w > CMP_W'(DIST_MAX))
			return DIST_MAX;
		return DIST_W'(w);
	endfunction

endpackage

// ===== hdl/nvs_ctrl.sv =====
module nvs_ctrl
	import nvs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic [KIND_W-1:0]   s_kind,
	input  logic                m_tready,
	input  logic [CNT_W-1:0]    count,
	input  sts_t                sts,
	output logic                s_tready,
	output logic                out_valid,
	output cmd_t                cmd
);

	state_t           state_q, state_nxt;
	logic [IDX_W-1:0] scan_idx_q;
	logic             out_valid_q;
	logic             scan_last;
	logic             slot_free;

	assign scan_last = (CNT_W'(scan_idx_q) == count - CNT_W'(1));
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && s_kind == KIND_QUERY)
					state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.done)
					state_nxt = ST_FETCH;
			end
			ST_FETCH: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (slot_free)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready       = 1'b0;
		cmd            = '0;
		cmd.scan_idx   = scan_idx_q;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.load  = s_tvalid && s_kind == KIND_LOAD;
				cmd.start = s_tvalid && s_kind == KIND_QUERY;
			end
			ST_SCAN: begin
				cmd.issue      = 1'b1;
				cmd.issue_last = scan_last;
			end
			ST_FETCH: cmd.fetch = 1'b1;
			ST_EMIT:  cmd.emit  = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_SCAN)
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			else
				scan_idx_q <= '0;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== hdl/nvs_datapath.sv =====
module nvs_datapath
	import nvs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  logic [METRIC_W-1:0]  metric,
	input  logic [SIDX_W-1:0]    in_index,
	input  logic [PT_W-1:0]      in_x,
	input  logic [PT_W-1:0]      in_y,
	input  logic [COLOR_W-1:0]   in_color,
	output sts_t                 sts,
	output logic [SIDX_W-1:0]    out_index,
	output logic [COLOR_W-1:0]   out_color,
	output logic [DIST_W-1:0]    out_dist
);

	// Site table: x in the low bits, then y, then the color word
	logic [ENTRY_W-1:0]    site_mem [MAX_SITES];
	logic [ENTRY_W-1:0]    mem_q;
	logic                  load_ok;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic                  rd_en;

	logic [COORD_BITS-1:0] px_q, py_q;

	assign load_ok = int'(in_index) < MAX_SITES;
	assign wr_addr = IDX_W'(in_index);
	assign rd_en   = cmd.issue || cmd.fetch;

	logic [IDX_W-1:0] best_i_q;
	logic [ROOT_W-1:0] best_d_q;

	assign rd_addr = cmd.fetch ? best_i_q : cmd.scan_idx;

	always_ff @(posedge clk) begin
		if (cmd.load && load_ok)
			site_mem[wr_addr] <= {in_color, COORD_BITS'(in_y), COORD_BITS'(in_x)};
		if (rd_en)
			mem_q <= site_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= COORD_BITS'(in_x);
			py_q <= COORD_BITS'(in_y);
		end
	end

	// s1: read data present
	logic             v_s1, last_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [COORD_BITS-1:0] sx, sy, dx, dy;

	assign sx = mem_q[COORD_BITS-1:0];
	assign sy = mem_q[SQ2_W-1:COORD_BITS];
	assign dx = (px_q >= sx) ? px_q - sx : sx - px_q;
	assign dy = (py_q >= sy) ? py_q - sy : sy - py_q;

	// s2: absolute differences
	logic             v_s2, last_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [COORD_BITS-1:0] dx_s2, dy_s2;

	// s3: squares and the non-Euclidean distance
	logic             v_s3, last_s3;
	logic [IDX_W-1:0] idx_s3;
	logic [SQ2_W-1:0] sqx_s3, sqy_s3;
	logic [ROOT_W-1:0] alt_s3;
	logic [ROOT_W-1:0] alt;

	always_comb begin
		case (metric)
			MET_MANHATTAN: alt = ROOT_W'(dx_s2) + ROOT_W'(dy_s2);
			MET_CHEBYSHEV: alt = (dx_s2 > dy_s2) ? ROOT_W'(dx_s2) : ROOT_W'(dy_s2);
			default:       alt = '0;
		endcase
	end

	// s4: sum of squares
	logic             v_s4, last_s4;
	logic [IDX_W-1:0] idx_s4;
	logic [SQ_W-1:0]  sum_s4;
	logic [ROOT_W-1:0] alt_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; last_s1 <= 1'b0;
			v_s2 <= 1'b0; last_s2 <= 1'b0;
			v_s3 <= 1'b0; last_s3 <= 1'b0;
			v_s4 <= 1'b0; last_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue; last_s1 <= cmd.issue_last;
			v_s2 <= v_s1;      last_s2 <= last_s1;
			v_s3 <= v_s2;      last_s3 <= last_s2;
			v_s4 <= v_s3;      last_s4 <= last_s3;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cmd.scan_idx;
		idx_s2 <= idx_s1;
		dx_s2  <= dx;
		dy_s2  <= dy;
		idx_s3 <= idx_s2;
		sqx_s3 <= SQ2_W'(dx_s2) * SQ2_W'(dx_s2);
		sqy_s3 <= SQ2_W'(dy_s2) * SQ2_W'(dy_s2);
		alt_s3 <= alt;
		idx_s4 <= idx_s3;
		sum_s4 <= SQ_W'(sqx_s3) + SQ_W'(sqy_s3);
		alt_s4 <= alt_s3;
	end

	// Integer square root, one result bit per stage
	logic [VPAD_W-1:0] rt_val_sk  [ROOT_W+1];
	logic [REM_W-1:0]  rt_rem_sk  [ROOT_W+1];
	logic [ROOT_W-1:0] rt_root_sk [ROOT_W+1];
	logic [ROOT_W-1:0] rt_alt_sk  [ROOT_W+1];
	logic [IDX_W-1:0]  rt_idx_sk  [ROOT_W+1];
	logic              rt_v_sk    [ROOT_W+1];
	logic              rt_last_sk [ROOT_W+1];

	assign rt_val_sk[0]  = VPAD_W'(sum_s4);
	assign rt_rem_sk[0]  = '0;
	assign rt_root_sk[0] = '0;
	assign rt_alt_sk[0]  = alt_s4;
	assign rt_idx_sk[0]  = idx_s4;
	assign rt_v_sk[0]    = v_s4;
	assign rt_last_sk[0] = last_s4;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_root
		logic [REM_W-1:0]  rem_in, trial, rem_out;
		logic [ROOT_W-1:0] root_out;

		always_comb begin
			rem_in = {rt_rem_sk[k][REM_W-3:0], rt_val_sk[k][VPAD_W-1 -: 2]};
			trial  = REM_W'({rt_root_sk[k], 2'b01});
			if (rem_in >= trial) begin
				rem_out  = rem_in - trial;
				root_out = {rt_root_sk[k][ROOT_W-2:0], 1'b1};
			end else begin
				rem_out  = rem_in;
				root_out = {rt_root_sk[k][ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_sk[k+1]    <= 1'b0;
				rt_last_sk[k+1] <= 1'b0;
			end else begin
				rt_v_sk[k+1]    <= rt_v_sk[k];
				rt_last_sk[k+1] <= rt_last_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			rt_val_sk[k+1]  <= rt_val_sk[k] << 2;
			rt_rem_sk[k+1]  <= rem_out;
			rt_root_sk[k+1] <= root_out;
			rt_alt_sk[k+1]  <= rt_alt_sk[k];
			rt_idx_sk[k+1]  <= rt_idx_sk[k];
		end
	end

	// Running minimum; strict less-than keeps the lowest index on ties
	logic [ROOT_W-1:0] d_fin;
	logic              done_q;

	assign d_fin = (metric == MET_EUCLID) ? rt_root_sk[ROOT_W] : rt_alt_sk[ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= rt_v_sk[ROOT_W] && rt_last_sk[ROOT_W];
	end

	always_ff @(posedge clk) begin
		if (rt_v_sk[ROOT_W] && (rt_idx_sk[ROOT_W] == '0 || d_fin < best_d_q)) begin
			best_d_q <= d_fin;
			best_i_q <= rt_idx_sk[ROOT_W];
		end
	end

	assign sts.done = done_q;

	// Output holding register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_index <= SIDX_W'(best_i_q);
			out_color <= mem_q[ENTRY_W-1:SQ2_W];
			out_dist  <= sat_dist(best_d_q);
		end
	end

endmodule

// ===== hdl/nearest_site_voronoi_search_unit.sv =====
// Nearest-site (Voronoi) search unit.
// Input stream (s_*): s_tuser is the item kind. A load item writes one site
// (x, y, color) into slot site_index and gives no result; a query item
// gives a pixel and yields exactly one result item on the output stream
// (m_*): index, color word and distance of the first nearest site.
// Config channel (cfg_*): index 0 sets site_count (sites scanned, 0 acts
// as 1), index 1 sets metric (0 Euclidean floor, 1 Manhattan, 2 Chebyshev,
// 3 gives distance 0). Write only while no query is in flight.
// A query scans one site per cycle out of the site table's single read
// port into a pipeline (read, difference, square, sum, then one stage per
// root bit of the square root); the root pipeline has 11 stages, and the
// color word is re-read from the table for the result item. The next item
// can be taken in the same cycle that the result item is offered.
// The input is held off while a query runs; loads resume once it is done.
// Reset clears the control state, sets site_count to 1 and metric to 0;
// site table contents are undefined until loaded.
// A stalled receiver leaves the result in the output register; the next
// query can still be taken and scanned, and only its result waits.
module nearest_site_voronoi_search_unit
	import nvs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [5:0] site_index, [15:6] point_x, [25:16] point_y, [57:26] site_color
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// [0] kind
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [5:0] nearest_index, [37:6] nearest_color, [48:38] nearest_distance
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFGIDX_W-1:0]   cfg_index,
	input  logic [SCOUNT_W-1:0]   cfg_data
);

	logic [SCOUNT_W-1:0] site_count_q;
	logic [METRIC_W-1:0] metric_q;
	logic [CNT_W-1:0]    count;

	cmd_t cmd;
	sts_t sts;

	logic [SIDX_W-1:0]  out_index;
	logic [COLOR_W-1:0] out_color;
	logic [DIST_W-1:0]  out_dist;

	assign cfg_ready = 1'b1;

	// Config registers; the user must write them only between queries, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			site_count_q <= SCOUNT_W'(1);
			metric_q     <= MET_EUCLID;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SITE_COUNT: site_count_q <= cfg_data;
				CFG_METRIC:     metric_q     <= cfg_data[METRIC_W-1:0];
				default: ;
			endcase
		end
	end

	assign count = eff_count(site_count_q);

	nvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_kind    (s_tuser),
		.m_tready  (m_tready),
		.count     (count),
		.sts       (sts),
		.s_tready  (s_tready),
		.out_valid (m_tvalid),
		.cmd       (cmd)
	);

	nvs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.metric    (metric_q),
		.in_index  (s_tdata[5:0]),
		.in_x      (s_tdata[15:6]),
		.in_y      (s_tdata[25:16]),
		.in_color  (s_tdata[57:26]),
		.sts       (sts),
		.out_index (out_index),
		.out_color (out_color),
		.out_dist  (out_dist)
	);

	assign m_tdata = {7'b0, out_dist, out_color, out_index};

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import nvs_pkg::*;

	// Metric code 3 has no name in the package: every distance reads as zero
	localparam logic [METRIC_W-1:0] MET_ZERO = 2'd3;
	localparam int CFG_PAD_W = SCOUNT_W - METRIC_W;

	// Idle time before a register write or the end of the run.
	localparam int SETTLE_CYCLES = 100;
	// Long receiver hold-off, long enough to back the block up to its input
	localparam int HOLD_CYCLES   = 800;
	localparam int PHASE_ITEMS   = 135;
	localparam int NUM_PHASES    = 14;

	typedef struct packed {
		logic [IDX_W-1:0]   index;
		logic [COLOR_W-1:0] color;
		logic [DIST_W-1:0]  distance;
	} nearest_t;

	// Shadow of the site table and registers; queues the answer of every
	// accepted query and checks result items against it in order.
	class voronoi_scoreboard;
		logic [PT_W-1:0]     site_x [MAX_SITES];
		logic [PT_W-1:0]     site_y [MAX_SITES];
		logic [COLOR_W-1:0]  site_color [MAX_SITES];
		logic [SCOUNT_W-1:0] scan_count;
		logic [METRIC_W-1:0] metric_sel;
		nearest_t            pending_results[$];
		int                  failures;
		int                  results_seen;

		function new();
			foreach (site_x[i]) begin
				site_x[i] = '0;
				site_y[i] = '0;
				site_color[i] = '0;
			end
			scan_count = 1;
			metric_sel = MET_EUCLID;
			failures = 0;
			results_seen = 0;
		endfunction

		function void write_reg(logic [CFGIDX_W-1:0] index, logic [SCOUNT_W-1:0] data);
			if (index == CFG_SITE_COUNT)
				scan_count = data;
			else
				metric_sel = data[METRIC_W-1:0];
		endfunction

		// Floor of the square root, one result bit at a time
		function int unsigned int_sqrt(int unsigned v);
			int unsigned root;
			int unsigned cand;
			root = 0;
			for (int b = 11; b >= 0; b--) begin
				cand = root | (32'd1 << b);
				if (cand * cand <= v)
					root = cand;
			end
			return root;
		endfunction

		function int unsigned site_distance(int unsigned px, int unsigned py,
				int unsigned sx, int unsigned sy);
			int unsigned dx;
			int unsigned dy;
			dx = (px >= sx) ? px - sx : sx - px;
			dy = (py >= sy) ? py - sy : sy - py;
			case (metric_sel)
				MET_EUCLID:    return int_sqrt(dx * dx + dy * dy);
				MET_MANHATTAN: return dx + dy;
				MET_CHEBYSHEV: return (dx > dy) ? dx : dy;
				default:       return 0;
			endcase
		endfunction

		// Strict less-than: the lowest index keeps a tie
		function nearest_t nearest_site(logic [PT_W-1:0] px, logic [PT_W-1:0] py);
			int unsigned n;
			int unsigned best_i;
			int unsigned best_d;
			int unsigned d;
			nearest_t r;
			n = scan_count;
			if (n == 0)
				n = 1;
			if (n > MAX_SITES)
				n = MAX_SITES;
			best_i = 0;
			best_d = site_distance(px, py, site_x[0], site_y[0]);
			for (int unsigned i = 1; i < n; i++) begin
				d = site_distance(px, py, site_x[i], site_y[i]);
				if (d < best_d) begin
					best_d = d;
					best_i = i;
				end
			end
			if (best_d > DIST_MAX)
				best_d = DIST_MAX;
			r.index = IDX_W'(best_i);
			r.color = site_color[best_i];
			r.distance = DIST_W'(best_d);
			return r;
		endfunction

		function void take_item(logic [KIND_W-1:0] kind, logic [SIDX_W-1:0] idx,
				logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [COLOR_W-1:0] color);
			if (kind == KIND_LOAD) begin
				site_x[idx] = x;
				site_y[idx] = y;
				site_color[idx] = color;
			end else begin
				pending_results.insert(pending_results.size(), nearest_site(x, y));
			end
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data);
			nearest_t want;
			nearest_t got;
			got.index = data[IDX_W-1:0];
			got.color = data[IDX_W +: COLOR_W];
			got.distance = data[IDX_W + COLOR_W +: DIST_W];
			results_seen++;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result %0d: unexpected, index %0d color %h distance %0d",
						results_seen, got.index, got.color, got.distance);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				failures++;
				if (failures <= 10)
					$display({"result %0d: expected index %0d color %h distance %0d, ",
						"got index %0d color %h distance %0d"}, results_seen,
						want.index, want.color, want.distance,
						got.index, got.color, got.distance);
			end
		endfunction
	endclass

	voronoi_scoreboard board = new();

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// [5:0] site_index, [15:6] point_x, [25:16] point_y, [57:26] site_color
	logic [S_TDATA_W-1:0] s_tdata;
	// [0] kind
	logic [KIND_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// [5:0] nearest_index, [37:6] nearest_color, [48:38] nearest_distance
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFGIDX_W-1:0]  cfg_index;
	logic [SCOUNT_W-1:0]  cfg_data;

	// Per-cycle idle odds of each side, in percent
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// Corner of the small window used to force clusters and ties
	logic [PT_W-1:0] base_x = '0;
	logic [PT_W-1:0] base_y = '0;
	logic holdoff_go = 1'b0;
	logic long_hold = 1'b0;

	nearest_site_voronoi_search_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: values read here are the ones the edge samples
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
		m_tready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// One long stall of the receiver while the sender keeps pushing
	initial begin
		wait (holdoff_go);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end

	// Offer one item, optionally after idle cycles; tvalid stays high after
	// acceptance so back-to-back items never toggle it within one step.
	task automatic send_item(logic [KIND_W-1:0] kind, logic [SIDX_W-1:0] idx,
			logic [PT_W-1:0] x, logic [PT_W-1:0] y, logic [COLOR_W-1:0] color);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= S_TDATA_W'({color, y, x, idx});
		do @(posedge clk); while (!s_tready);
		board.take_item(kind, idx, x, y, color);
	endtask

	task automatic write_register(logic [CFGIDX_W-1:0] index, logic [SCOUNT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(index, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain every expected result, then give a trailing load time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Half uniform, often a tight window (ties, equal sites), some extremes
	function automatic logic [PT_W-1:0] pick_coord(int style, logic [PT_W-1:0] base);
		if (style < 50)
			return PT_W'($urandom_range(1023));
		if (style < 85)
			return base + PT_W'($urandom_range(7));
		return $urandom_range(1) ? PT_W'(1023) : PT_W'(0);
	endfunction

	function automatic logic [COLOR_W-1:0] pick_color();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic random_item();
		logic [KIND_W-1:0] kind;
		int style;
		kind = ($urandom_range(99) < 55) ? KIND_QUERY : KIND_LOAD;
		style = $urandom_range(99);
		send_item(kind, SIDX_W'($urandom_range(MAX_SITES - 1)),
			pick_coord(style, base_x), pick_coord(style, base_y), pick_color());
	endtask

	task automatic run_phase(logic [SCOUNT_W-1:0] count, logic [METRIC_W-1:0] metric,
			int mode, bit hold);
		settle();
		write_register(CFG_SITE_COUNT, count);
		// upper bits of a metric write carry noise; only the low two count
		write_register(CFG_METRIC, {CFG_PAD_W'($urandom), metric});
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
			default: begin send_idle_pct = 36; recv_stall_pct = 36; end
		endcase
		base_x = PT_W'($urandom_range(1016));
		base_y = PT_W'($urandom_range(1016));
		if (hold)
			holdoff_go = 1'b1;
		repeat (PHASE_ITEMS) random_item();
	endtask

	initial begin
		int phase_count[NUM_PHASES] = '{1, 64, 127, 2, 0, 65, 8, 33, 64, 17, 3, 64, 5, 40};
		logic [METRIC_W-1:0] phase_metric[NUM_PHASES] = '{
			MET_EUCLID, MET_MANHATTAN, MET_CHEBYSHEV, MET_ZERO, MET_EUCLID,
			MET_CHEBYSHEV, MET_MANHATTAN, MET_EUCLID, MET_EUCLID, MET_CHEBYSHEV,
			MET_MANHATTAN, MET_ZERO, MET_EUCLID, MET_MANHATTAN};

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_LOAD;
		cfg_valid = 1'b0;
		cfg_index = CFG_SITE_COUNT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, reset registers: one site, Euclidean floor.
		// Only sites already loaded are ever scanned.
		send_item(KIND_LOAD, 0, 0, 0, 32'h0000_0000);
		send_item(KIND_QUERY, 0, 0, 0, 32'h0000_0000);
		send_item(KIND_QUERY, 0, 1023, 1023, 32'h0000_0000);    // longest diagonal
		send_item(KIND_LOAD, 0, 1023, 1023, 32'hffff_ffff);
		send_item(KIND_QUERY, 0, 0, 0, 32'h0000_0000);
		send_item(KIND_QUERY, 0, 1023, 0, 32'hffff_ffff);
		send_item(KIND_LOAD, 1, 1023, 1023, 32'h5a5a_a5a5);      // same spot as site 0
		send_item(KIND_LOAD, 63, 0, 1023, 32'hc3c3_3c3c);

		// Two sites, Manhattan: equal distances keep the lower index
		settle();
		write_register(CFG_SITE_COUNT, 2);
		write_register(CFG_METRIC, MET_MANHATTAN);
		send_item(KIND_QUERY, 0, 0, 0, 32'h0000_0000);           // distance 2046
		send_item(KIND_LOAD, 1, 0, 0, 32'h0f0f_f0f0);
		send_item(KIND_QUERY, 0, 0, 0, 32'h0000_0000);
		send_item(KIND_QUERY, 0, 1023, 1023, 32'h0000_0000);

		// Chebyshev tie between the two sites
		settle();
		write_register(CFG_METRIC, MET_CHEBYSHEV);
		send_item(KIND_QUERY, 0, 0, 1023, 32'h0000_0000);

		// Metric code 3, upper data bits set: site 0 at distance zero
		settle();
		write_register(CFG_METRIC, '1);
		send_item(KIND_QUERY, 0, 700, 300, 32'h0000_0000);

		// Count of zero scans site 0 alone
		settle();
		write_register(CFG_SITE_COUNT, 0);
		write_register(CFG_METRIC, MET_EUCLID);
		send_item(KIND_QUERY, 0, 0, 0, 32'h0000_0000);

		// Load the whole table so any count is safe from here on
		settle();
		base_x = PT_W'($urandom_range(1016));
		base_y = PT_W'($urandom_range(1016));
		for (int i = 0; i < MAX_SITES; i++)
			send_item(KIND_LOAD, SIDX_W'(i), pick_coord($urandom_range(99), base_x),
				pick_coord($urandom_range(99), base_y), pick_color());

		// Random phases; the long receiver hold lands on a phase with no idling
		for (int p = 0; p < NUM_PHASES; p++)
			run_phase(SCOUNT_W'(phase_count[p]), phase_metric[p], p % 4, p == 8);

		settle();
		if (board.failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
